// ===== hdl/acm_pkg.sv =====
// Shared constants, types and helper functions of the ASCII command monitor.
package acm_pkg;

    localparam int BUF_CHARS   = 32;
    localparam int MEM_BYTES   = 4096;
    localparam int FILL_W      = $clog2(BUF_CHARS + 1);
    localparam int ADDR_W      = $clog2(MEM_BYTES);
    // Only the first eleven buffer positions are ever looked at by a command.
    localparam int STORE_CHARS = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_CAN   = 8'h18;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [16:0] IO_OFFSET = 17'h00020;

    localparam int ERR_LEN = 15;
    localparam logic [8*ERR_LEN-1:0] ERR_TEXT = "! Command Error";

    // Output slots in transmit order; a word carries one enabled slot.
    localparam int SL_PRE_CR  = 0;
    localparam int SL_PRE_LF  = 1;
    localparam int SL_SPACE   = 2;
    localparam int SL_HI      = 3;
    localparam int SL_LO      = 4;
    localparam int SL_ERR_CR  = 5;
    localparam int SL_ERR_LF  = 6;
    localparam int SL_ERR_TXT = 7;
    localparam int SL_PR_CR   = SL_ERR_TXT + ERR_LEN;
    localparam int SL_PR_LF   = SL_PR_CR + 1;
    localparam int SL_MARK    = SL_PR_CR + 2;
    localparam int SL_GT      = SL_PR_CR + 3;
    localparam int SL_ECHO    = SL_PR_CR + 4;
    localparam int SLOTS      = SL_ECHO + 1;

    typedef logic [SLOTS-1:0] slot_mask_t;

    typedef struct packed {
        slot_mask_t  mask;
        logic [7:0]  mark;
        logic [7:0]  echo;
        logic [7:0]  data;
    } job_t;

    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return 5'(ch - "0");
        if (ch >= "A" && ch <= "F") return 5'(ch - "A" + 8'd10);
        if (ch >= "a" && ch <= "f") return 5'(ch - "a" + 8'd10);
        return 5'd16;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? 8'("0" + v) : 8'("A" + v - 4'd10);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") ? 8'(ch - 8'h20) : ch;
    endfunction

    function automatic logic [7:0] slot_char(input int i, input job_t j);
        if (i == SL_PRE_CR || i == SL_ERR_CR || i == SL_PR_CR) return CH_CR;
        if (i == SL_PRE_LF || i == SL_ERR_LF || i == SL_PR_LF) return CH_LF;
        if (i == SL_SPACE) return CH_SPACE;
        if (i == SL_HI) return hex_digit(j.data[7:4]);
        if (i == SL_LO) return hex_digit(j.data[3:0]);
        if (i == SL_MARK) return j.mark;
        if (i == SL_GT) return CH_GT;
        if (i == SL_ECHO) return j.echo;
        if (i >= SL_ERR_TXT && i < SL_ERR_TXT + ERR_LEN)
            return ERR_TEXT[8*(ERR_LEN-1-(i-SL_ERR_TXT)) +: 8];
        return 8'h00;
    endfunction

endpackage

// ===== hdl/acm_rx_if.sv =====
// Receive channel: one received character per word.
interface acm_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

// ===== hdl/acm_tx_if.sv =====
// Transmit channel: one response character per word.
interface acm_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_char;
    logic       last_of_run;

    modport source (output valid, output tx_char, output last_of_run, input ready);
    modport sink   (input valid, input tx_char, input last_of_run, output ready);
endinterface

// ===== hdl/acm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== hdl/acm_front.sv =====
// Front end: takes characters, keeps the command buffer, decodes and runs commands.
module acm_front
    import acm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    acm_rx_if.sink     rx,
    output job_t       job,
    output logic       job_valid,
    input  logic       job_ready
);

    logic [7:0]        buf_reg [STORE_CHARS];
    logic [FILL_W-1:0] fill_reg;
    logic              mode_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              s2_valid_reg;
    job_t              s2_job_reg;
    logic              s2_rd_ok_reg;

    logic [7:0]  bufv [STORE_CHARS];
    logic        hx [STORE_CHARS];
    logic        accept, push;
    logic        is_cr, is_print, is_cancel, do_exec;
    logic [7:0]  a, b;
    logic        c_im, c_rm, c_ip, c_wm, c_op, c_ee, c_nop, known;
    logic        wm_ok, op_ok, failed, new_mode, in_range, do_write;
    logic [15:0] arg3, arg6, arg7;
    logic [16:0] addr;
    logic [7:0]  wval, rdata;
    logic        has_job;
    job_t        job_next;

    function automatic logic [15:0] parse4(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [7:0] c2, input logic [7:0] c3);
        logic [15:0] acc;
        logic        stop;
        logic [4:0]  d;
        logic [7:0]  cs [4];
        acc  = '0;
        stop = 1'b0;
        cs[0] = c0; cs[1] = c1; cs[2] = c2; cs[3] = c3;
        for (int k = 0; k < 4; k++)
        begin
            d = hex_value(cs[k]);
            if (d[4])
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                acc = {acc[11:0], d[3:0]};
            end
        end
        return acc;
    endfunction

    always_comb
    begin
        for (int k = 0; k < STORE_CHARS; k++)
        begin
            bufv[k] = (k < BUF_CHARS) ? buf_reg[k] : 8'h00;
            hx[k]   = (hex_value(bufv[k]) < 5'd16);
        end
    end

    assign rx.ready  = !clearing_reg && (!s2_valid_reg || job_ready);
    assign accept    = rx.valid && rx.ready;
    assign push      = s2_valid_reg && job_ready;
    assign job_valid = s2_valid_reg;

    assign is_cr     = (rx.rx_char == CH_CR);
    assign is_print  = (rx.rx_char >= CH_SPACE) && (rx.rx_char <= CH_TILDE);
    assign is_cancel = (rx.rx_char == CH_ESC) || (rx.rx_char == CH_CAN);
    assign do_exec   = is_cr && (fill_reg != '0);

    assign a = fold(bufv[0]);
    assign b = fold(bufv[1]);
    assign c_im = (a == "I") && (b == "M");
    assign c_rm = (a == "R") && (b == "M");
    assign c_ip = (a == "I") && (b == "P");
    assign c_wm = (a == "W") && (b == "M");
    assign c_op = (a == "O") && (b == "P");
    assign c_ee = (a == "E") && (b == "E");
    assign c_nop = ((a == "D") && (b == "P" || b == "C" || b == "D" || b == "E")) ||
                   ((a == "L") && (b == "S")) || ((a == "V") && (b == "N")) ||
                   ((a == "W") && (b == "D")) || ((a == "S") && (b == "E" || b == "F")) ||
                   ((a == "R") && (b == "S"));
    assign known = c_im || c_rm || c_ip || c_wm || c_op || c_ee || c_nop;

    assign wm_ok = hx[3] && hx[4] && hx[5] && (bufv[6] == CH_SPACE) && hx[7] && hx[8];
    assign op_ok = hx[3] && hx[4] && (bufv[5] == CH_SPACE) && hx[6] && hx[7];

    assign arg3 = parse4(bufv[3], bufv[4], bufv[5], bufv[6]);
    assign arg6 = parse4(bufv[6], bufv[7], bufv[8], bufv[9]);
    assign arg7 = parse4(bufv[7], bufv[8], bufv[9], bufv[10]);
    assign addr = (c_ip || c_op) ? ({1'b0, arg3} + IO_OFFSET) : {1'b0, arg3};
    assign in_range = (addr < 17'(MEM_BYTES));
    assign wval = c_op ? arg6[7:0] : arg7[7:0];

    assign failed   = !known || c_ee || (c_wm && !wm_ok) || (c_op && !op_ok);
    assign new_mode = c_im ? (bufv[3] == "1" || bufv[3] == "Y" || bufv[3] == "y") : mode_reg;
    assign do_write = accept && do_exec && ((c_wm && wm_ok) || (c_op && op_ok)) && in_range;

    always_comb
    begin
        job_next      = '0;
        job_next.echo = rx.rx_char;
        has_job       = 1'b0;
        if (do_exec)
        begin
            has_job = 1'b1;
            if (known && mode_reg)
            begin
                job_next.mask[SL_PRE_CR] = 1'b1;
                job_next.mask[SL_PRE_LF] = 1'b1;
            end
            if (c_rm || c_ip)
            begin
                job_next.mask[SL_SPACE] = mode_reg;
                job_next.mask[SL_HI]    = 1'b1;
                job_next.mask[SL_LO]    = 1'b1;
            end
            if (failed && mode_reg && !c_ee)
            begin
                job_next.mask[SL_ERR_CR] = 1'b1;
                job_next.mask[SL_ERR_LF] = 1'b1;
                job_next.mask[SL_ERR_TXT +: ERR_LEN] = '1;
            end
            job_next.mask[SL_PR_CR] = 1'b1;
            job_next.mask[SL_PR_LF] = 1'b1;
            job_next.mask[SL_MARK]  = 1'b1;
            job_next.mask[SL_GT]    = new_mode;
            job_next.mark = failed ? CH_BANG : (new_mode ? CH_EQ : CH_DASH);
        end
        else if (is_cr || is_cancel)
        begin
            has_job = 1'b1;
            job_next.mask[SL_PR_CR] = 1'b1;
            job_next.mask[SL_PR_LF] = 1'b1;
            job_next.mask[SL_MARK]  = 1'b1;
            job_next.mask[SL_GT]    = mode_reg;
            job_next.mark = mode_reg ? CH_EQ : CH_DASH;
        end
        else if (is_print && mode_reg)
        begin
            has_job = 1'b1;
            job_next.mask[SL_ECHO] = 1'b1;
        end
    end

    acm_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (clearing_reg || do_write),
        .waddr (clearing_reg ? clr_cnt_reg : addr[ADDR_W-1:0]),
        .wdata (clearing_reg ? 8'h00 : wval),
        .re    (accept),
        .raddr (addr[ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        job      = s2_job_reg;
        job.data = s2_rd_ok_reg ? rdata : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STORE_CHARS; k++)
            begin
                buf_reg[k] <= 8'h00;
            end
            fill_reg     <= '0;
            mode_reg     <= 1'b0;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(MEM_BYTES - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                s2_valid_reg <= has_job;
                if (is_print && (fill_reg < FILL_W'(BUF_CHARS)))
                begin
                    for (int k = 0; k < STORE_CHARS; k++)
                    begin
                        if (fill_reg == FILL_W'(k))
                        begin
                            buf_reg[k] <= rx.rx_char;
                        end
                    end
                    fill_reg <= fill_reg + 1'b1;
                end
                else if (is_cr || is_cancel)
                begin
                    for (int k = 0; k < STORE_CHARS; k++)
                    begin
                        buf_reg[k] <= 8'h00;
                    end
                    fill_reg <= '0;
                    if (do_exec)
                    begin
                        mode_reg <= new_mode;
                    end
                end
            end
            else if (push)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_job_reg   <= job_next;
            s2_rd_ok_reg <= do_exec && (c_rm || c_ip) && in_range;
        end
    end

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !clearing_reg)
        else $error("character taken during memory clear");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !job_ready) |=> (s2_valid_reg && $stable(s2_job_reg)))
        else $error("pending response lost while queue full");

endmodule

// ===== hdl/acm_queue.sv =====
// Short queue of response descriptors between the front and back ends.
module acm_queue
    import acm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("response queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("response queue underflow");

endmodule

// ===== hdl/acm_back.sv =====
// Back end: turns response descriptors into transmitted characters.
module acm_back
    import acm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  job_t   q_job,
    input  logic   q_empty,
    output logic   pop,
    acm_tx_if.source tx
);

    slot_mask_t mask_reg;
    job_t       job_reg;

    slot_mask_t onehot;
    logic       hs, last;
    logic [7:0] ch;

    assign onehot = mask_reg & (~mask_reg + 1'b1);
    assign last   = ((mask_reg & (mask_reg - 1'b1)) == '0);
    assign hs     = tx.valid && tx.ready;
    assign pop    = !q_empty && ((mask_reg == '0) || (hs && last));

    always_comb
    begin
        ch = 8'h00;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (onehot[i])
            begin
                ch = ch | slot_char(i, job_reg);
            end
        end
    end

    assign tx.valid       = (mask_reg != '0);
    assign tx.tx_char     = ch;
    assign tx.last_of_run = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (pop)
        begin
            mask_reg <= q_job.mask;
        end
        else if (hs)
        begin
            mask_reg <= mask_reg & ~onehot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
        end
    end

    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (hs && last && q_empty) |=> !tx.valid)
        else $error("output continues after final word of a run");

endmodule

// ===== hdl/ascii_command_monitor_unit.sv =====
// The first response word passes the front-end stage register, the descriptor queue and
// the back-end mask register. Throughput: one character taken per cycle unless memory is
// clearing or the queue is full with a response pending; responses leave at one word per
// cycle while tx.ready is high, through a four-entry descriptor queue that stalls intake
// only when full. Reset clears buffer, mode and queue at once, then a clearing pass writes
// zero to all 4096 memory bytes, one per cycle, with rx.ready held low until it ends.
module ascii_command_monitor_unit
    import acm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    acm_rx_if.sink   rx,
    acm_tx_if.source tx
);

    job_t front_job, head_job;
    logic front_valid, q_full, q_empty, q_pop;

    acm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (!q_full)
    );

    acm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_valid && !q_full),
        .push_job (front_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_job),
        .empty    (q_empty)
    );

    acm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_job   (head_job),
        .q_empty (q_empty),
        .pop     (q_pop),
        .tx      (tx)
    );

endmodule
